[sv/ubds_pkg.sv]
// Shared widths, constants and types of the UART baud divisor search unit.
package ubds_pkg;

  localparam int unsigned BAUD_W = 23;
  localparam int unsigned DIV_W = 32;
  localparam int unsigned DIVR_W = 16;
  localparam int unsigned OSR_W = 6;
  localparam int unsigned OSRI_W = 7;

  localparam int unsigned OSR_LOW_DEF = 4;
  localparam int unsigned OSR_HIGH_DEF = 32;
  localparam int unsigned DIVISOR_LIMIT_DEF = 8191;

  localparam logic [DIV_W-1:0] CLK_RESET = 32'd80000000;

  localparam int unsigned RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned Q100_W = 17;
  localparam int unsigned FAULT_MUL = 3;

  localparam int unsigned LANE_LAT = 2 * DIV_W + 3;

  typedef struct packed {
    logic [DIV_W-1:0]  err;
    logic [DIVR_W-1:0] div;
    logic [OSR_W-1:0]  osr;
  } best_t;

endpackage

[sv/ubds_div_cell.sv]
// One restoring division step, registered, as a cell of the divider chain.
module ubds_div_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     num_bit,
  input  logic [ubds_pkg::DIV_W-1:0] rem_in,
  input  logic [ubds_pkg::DIV_W-1:0] quo_in,
  input  logic [ubds_pkg::DIV_W-1:0] den_in,
  output logic [ubds_pkg::DIV_W-1:0] rem_out,
  output logic [ubds_pkg::DIV_W-1:0] quo_out,
  output logic [ubds_pkg::DIV_W-1:0] den_out
);
  import ubds_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_in, num_bit};
    diff  = trial - {1'b0, den_in};
    ge    = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_out <= {quo_in[DIV_W-2:0], ge};
      den_out <= den_in;
    end
  end

endmodule

[sv/ubds_divider.sv]
// Pipelined divider built as a chain of restoring division cells, one bit per stage.
module ubds_divider (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ubds_pkg::DIV_W-1:0] numer,
  input  logic [ubds_pkg::DIV_W-1:0] den,
  output logic [ubds_pkg::DIV_W-1:0] quo
);
  import ubds_pkg::*;

  logic [DIV_W-1:0] rem_c [0:DIV_W];
  logic [DIV_W-1:0] quo_c [0:DIV_W];
  logic [DIV_W-1:0] den_c [0:DIV_W];

  assign rem_c[0] = '0;
  assign quo_c[0] = '0;
  assign den_c[0] = den;

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    ubds_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .num_bit (numer[DIV_W-1-i]),
      .rem_in  (rem_c[i]),
      .quo_in  (quo_c[i]),
      .den_in  (den_c[i]),
      .rem_out (rem_c[i+1]),
      .quo_out (quo_c[i+1]),
      .den_out (den_c[i+1])
    );
  end

  assign quo = quo_c[DIV_W];

endmodule

[sv/ubds_lane.sv]
// Candidate divisor and error for one oversampling ratio, fully pipelined.
module ubds_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ubds_pkg::OSRI_W-1:0] osr,
  input  logic [ubds_pkg::DIV_W-1:0]  src_clk,
  input  logic [ubds_pkg::BAUD_W-1:0] baud_in,
  input  logic [ubds_pkg::BAUD_W-1:0] baud_late,
  output logic [ubds_pkg::DIV_W-1:0]  cand_err,
  output logic [ubds_pkg::DIVR_W-1:0] cand_div
);
  import ubds_pkg::*;

  logic [DIV_W-1:0]    den_a;
  logic [DIV_W-1:0]    quo_a;
  logic [DIVR_W-1:0]   div_clamp;
  logic [DIV_W-1:0]    m_lo;
  logic [DIV_W-1:0]    m_hi;
  logic [DIV_W-1:0]    quo_lo;
  logic [DIV_W-1:0]    quo_hi;
  logic [DIVR_W-1:0]   div_line [0:DIV_W];
  logic [DIV_W-1:0]    err_dn;
  logic [DIV_W-1:0]    err_up;
  logic [DIVR_W-1:0]   div_end;

  always_ff @(posedge clk) begin
    if (en) begin
      den_a <= DIV_W'(baud_in) * DIV_W'(osr);
    end
  end

  ubds_divider u_div_a (.clk(clk), .en(en), .numer(src_clk), .den(den_a), .quo(quo_a));

  always_comb begin
    div_clamp = (quo_a[DIVR_W-1:0] == '0) ? DIVR_W'(1) : quo_a[DIVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_lo        <= DIV_W'(div_clamp) * DIV_W'(osr);
      m_hi        <= (DIV_W'(div_clamp) + DIV_W'(1)) * DIV_W'(osr);
      div_line[0] <= div_clamp;
      for (int i = 1; i <= DIV_W; i++) begin
        div_line[i] <= div_line[i-1];
      end
    end
  end

  ubds_divider u_div_lo (.clk(clk), .en(en), .numer(src_clk), .den(m_lo), .quo(quo_lo));
  ubds_divider u_div_hi (.clk(clk), .en(en), .numer(src_clk), .den(m_hi), .quo(quo_hi));

  always_comb begin
    err_dn  = quo_lo - DIV_W'(baud_late);
    err_up  = DIV_W'(baud_late) - quo_hi;
    div_end = div_line[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (err_dn > err_up) begin
        cand_err <= err_up;
        cand_div <= div_end + DIVR_W'(1);
      end else begin
        cand_err <= err_dn;
        cand_div <= div_end;
      end
    end
  end

endmodule

[sv/ubds_sel_cell.sv]
// One link of the best-candidate chain: keeps the later ratio when its error is no larger.
module ubds_sel_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ubds_pkg::OSR_W-1:0]  osr,
  input  logic [ubds_pkg::DIV_W-1:0]  cand_err,
  input  logic [ubds_pkg::DIVR_W-1:0] cand_div,
  input  ubds_pkg::best_t             prev,
  output ubds_pkg::best_t             next
);
  import ubds_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      if (cand_err <= prev.err) begin
        next.err <= cand_err;
        next.div <= cand_div;
        next.osr <= osr;
      end else begin
        next <= prev;
      end
    end
  end

endmodule

[sv/uart_baud_divisor_search_unit.sv]
// Top level of the UART baud divisor and oversampling search unit.
// Each transaction on the input channel carries a requested baud rate and yields one result
// transaction with the chosen divisor, oversampling ratio, rate error and fault flag. The unit
// accepts one request per clock while the output is not stalled and returns results in order; each
// request passes through three 32-stage restoring divider chains per ratio, the last two side by
// side, followed by a chain of selection cells, one per ratio. The whole pipeline advances together
// and holds while a result waits to be taken.
// The clock frequency register is written through its own channel, which is always ready, and
// should only be written while no request is in flight.
module uart_baud_divisor_search_unit #(
  parameter int unsigned OSR_LOW = ubds_pkg::OSR_LOW_DEF,
  parameter int unsigned OSR_HIGH = ubds_pkg::OSR_HIGH_DEF,
  parameter int unsigned DIVISOR_LIMIT = ubds_pkg::DIVISOR_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ubds_pkg::BAUD_W-1:0] baud_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ubds_pkg::DIVR_W-1:0] divisor,
  output logic [ubds_pkg::OSR_W-1:0]  oversample,
  output logic [ubds_pkg::DIV_W-1:0]  rate_error,
  output logic                        fault,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ubds_pkg::DIV_W-1:0]  cfg_data
);
  import ubds_pkg::*;

  localparam int unsigned NL = OSR_HIGH - OSR_LOW + 1;
  localparam int unsigned S = NL + LANE_LAT;
  localparam int unsigned PROD_W = BAUD_W + RECIP_W;

  logic                en;
  logic [DIV_W-1:0]    source_clock_hz;
  logic [BAUD_W-1:0]   b [0:S];
  logic                v [0:S+1];
  logic [DIV_W-1:0]    cand_err [0:NL-1];
  logic [DIVR_W-1:0]   cand_div [0:NL-1];
  best_t               chain [0:NL];
  best_t               fbest;
  logic [Q100_W-1:0]   fq100;
  logic [PROD_W-1:0]   prod100;
  logic [Q100_W+1:0]   limit3;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_clock_hz <= CLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      source_clock_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b[0] <= baud_rate;
      for (int i = 1; i <= S; i++) begin
        b[i] <= b[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= S + 1; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i <= S + 1; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  assign chain[0].err = DIV_W'(b[LANE_LAT]);
  assign chain[0].div = '0;
  assign chain[0].osr = '0;

  for (genvar k = 0; k < NL; k++) begin : g_lane
    ubds_lane u_lane (
      .clk       (clk),
      .en        (en),
      .osr       (OSRI_W'(OSR_LOW + k)),
      .src_clk   (source_clock_hz),
      .baud_in   (b[k]),
      .baud_late (b[k+LANE_LAT-1]),
      .cand_err  (cand_err[k]),
      .cand_div  (cand_div[k])
    );

    ubds_sel_cell u_sel (
      .clk      (clk),
      .en       (en),
      .osr      (OSR_W'(OSR_LOW + k)),
      .cand_err (cand_err[k]),
      .cand_div (cand_div[k]),
      .prev     (chain[k]),
      .next     (chain[k+1])
    );
  end

  assign prod100 = PROD_W'(b[S]) * PROD_W'(RECIP_100);
  assign limit3  = (Q100_W+2)'(fq100) * (Q100_W+2)'(FAULT_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      fbest <= chain[NL];
      fq100 <= prod100[RECIP_SHIFT +: Q100_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[S+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divisor    <= fbest.div;
      oversample <= fbest.osr;
      rate_error <= fbest.err;
      fault      <= (fbest.err > DIV_W'(limit3)) || (fbest.div > DIVR_W'(DIVISOR_LIMIT));
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid straight after reset.");

  a_none_zero_div: assert property (@(posedge clk) disable iff (rst)
    (out_valid && oversample == '0 && OSR_HIGH < (1 << OSR_W)) |-> divisor == '0)
    else $error("No candidate chosen but divisor is not zero.");

  a_osr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (oversample == '0 || oversample >= OSR_W'(OSR_LOW) || OSR_HIGH >= (1 << OSR_W)))
    else $error("Oversampling ratio below the searched range.");

  a_limit_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divisor > DIVR_W'(DIVISOR_LIMIT)) |-> fault)
    else $error("Divisor above the limit without a fault.");

endmodule
